@@ sv/bin_tl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bin_tl_pkg
// Shared types and constants for the BIN paper-tape loader.
// ----------------------------------------------------------------------------
package bin_tl_pkg;

  // Field number width kept from the field byte (bits 5:3)
  localparam int unsigned FIELD_BITS   = 3;
  // Field slot in the 15-bit word address
  localparam int unsigned FIELD_SLOT_W = 3;
  localparam int unsigned ADDR_W       = 12;
  localparam int unsigned WORD_W       = 12;
  localparam int unsigned WADDR_W      = FIELD_SLOT_W + ADDR_W;
  localparam int unsigned BSUM_W       = 9;

  // Loader phase codes
  localparam logic [1:0] PH_LEADER = 2'd0;
  localparam logic [1:0] PH_BODY   = 2'd1;
  localparam logic [1:0] PH_ORG2   = 2'd2;
  localparam logic [1:0] PH_DATA2  = 2'd3;

  // Byte kind, top two bits
  localparam logic [1:0] KIND_DATA    = 2'b00;
  localparam logic [1:0] KIND_ORIGIN  = 2'b01;
  localparam logic [1:0] KIND_TRAILER = 2'b10;
  localparam logic [1:0] KIND_FIELD   = 2'b11;

  localparam logic [7:0] BLANK_BYTE   = 8'h00;
  localparam logic [7:0] TRAILER_BYTE = 8'h80;

  typedef struct packed {
    logic               write_valid;
    logic [WADDR_W-1:0] word_address;
    logic [WORD_W-1:0]  word_data;
    logic               tape_done;
    logic               checksum_good;
    logic               bad_frame;
    logic [WORD_W-1:0]  computed_sum;
  } result_t;

endpackage

@@ sv/bin_tl_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bin_tl_core
// Frame decoder and loader state; one tape byte per transfer.
// ----------------------------------------------------------------------------
module bin_tl_core import bin_tl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  logic [7:0] byte_i,
  output logic       res_valid_o,
  output result_t    res_o,
  output logic [1:0] phase_o
);

  logic [1:0]            phase_q, phase_d;
  logic [FIELD_BITS-1:0] field_q, field_d;
  logic [ADDR_W-1:0]     next_addr_q, next_addr_d;
  logic [5:0]            high_six_q, high_six_d;
  logic [WORD_W-1:0]     sum_q, sum_d;
  logic                  pend_valid_q, pend_valid_d;
  logic [WADDR_W-1:0]    pend_addr_q, pend_addr_d;
  logic [WORD_W-1:0]     pend_word_q, pend_word_d;
  logic [BSUM_W-1:0]     pend_bsum_q, pend_bsum_d;

  always_comb begin
    logic                  leader;
    logic                  go_clear;
    logic [1:0]            kind;
    logic [ADDR_W-1:0]     eff_addr;
    logic [FIELD_BITS-1:0] eff_field;
    logic [WORD_W-1:0]     eff_sum;
    logic                  eff_pv;

    phase_d      = phase_q;
    field_d      = field_q;
    next_addr_d  = next_addr_q;
    high_six_d   = high_six_q;
    sum_d        = sum_q;
    pend_valid_d = pend_valid_q;
    pend_addr_d  = pend_addr_q;
    pend_word_d  = pend_word_q;
    pend_bsum_d  = pend_bsum_q;
    res_valid_o  = 1'b0;
    res_o        = '0;
    go_clear     = 1'b0;

    leader    = (phase_q == PH_LEADER);
    kind      = byte_i[7:6];
    // first body byte starts a fresh tape
    eff_field = leader ? '0 : field_q;
    eff_addr  = leader ? '0 : next_addr_q;
    eff_sum   = leader ? '0 : sum_q;
    eff_pv    = !leader && pend_valid_q;

    unique case (phase_q)
      PH_LEADER, PH_BODY: begin
        if (leader && (byte_i == BLANK_BYTE || byte_i == TRAILER_BYTE)) begin
          // leader: skip
        end else if (kind == KIND_TRAILER) begin
          res_valid_o = 1'b1;
          go_clear    = 1'b1;
          if (byte_i != TRAILER_BYTE) begin
            res_o.bad_frame = 1'b1;
          end else begin
            res_o.tape_done     = 1'b1;
            res_o.checksum_good = pend_valid_q && (pend_word_q == sum_q);
            res_o.computed_sum  = sum_q;
          end
        end else begin
          field_d      = eff_field;
          next_addr_d  = eff_addr;
          high_six_d   = leader ? '0 : high_six_q;
          pend_valid_d = 1'b0;
          if (eff_pv) begin
            // next frame commits the held word
            eff_sum            = eff_sum + WORD_W'(pend_bsum_q);
            res_valid_o        = 1'b1;
            res_o.write_valid  = 1'b1;
            res_o.word_address = pend_addr_q;
            res_o.word_data    = pend_word_q;
          end
          unique case (kind)
            KIND_FIELD: begin
              field_d = byte_i[3 +: FIELD_BITS];
              phase_d = PH_BODY;
            end
            KIND_ORIGIN: begin
              eff_sum    = eff_sum + WORD_W'(byte_i);
              high_six_d = byte_i[5:0];
              phase_d    = PH_ORG2;
            end
            default: begin
              high_six_d = byte_i[5:0];
              phase_d    = PH_DATA2;
            end
          endcase
          sum_d = eff_sum;
        end
      end
      PH_ORG2: begin
        if (byte_i == TRAILER_BYTE) begin
          res_valid_o     = 1'b1;
          res_o.bad_frame = 1'b1;
          go_clear        = 1'b1;
        end else begin
          next_addr_d = {high_six_q, byte_i[5:0]};
          sum_d       = sum_q + WORD_W'(byte_i);
          phase_d     = PH_BODY;
        end
      end
      default: begin
        if (byte_i == TRAILER_BYTE) begin
          res_valid_o     = 1'b1;
          res_o.bad_frame = 1'b1;
          go_clear        = 1'b1;
        end else begin
          pend_word_d  = {high_six_q, byte_i[5:0]};
          pend_addr_d  = {FIELD_SLOT_W'(field_q), next_addr_q};
          pend_bsum_d  = BSUM_W'(high_six_q) + BSUM_W'(byte_i);
          pend_valid_d = 1'b1;
          next_addr_d  = next_addr_q + ADDR_W'(1);
          phase_d      = PH_BODY;
        end
      end
    endcase

    if (go_clear) begin
      phase_d      = PH_LEADER;
      field_d      = '0;
      next_addr_d  = '0;
      high_six_d   = '0;
      sum_d        = '0;
      pend_valid_d = 1'b0;
      pend_addr_d  = '0;
      pend_word_d  = '0;
      pend_bsum_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_LEADER;
      field_q      <= '0;
      next_addr_q  <= '0;
      high_six_q   <= '0;
      sum_q        <= '0;
      pend_valid_q <= 1'b0;
    end else if (fire_i) begin
      phase_q      <= phase_d;
      field_q      <= field_d;
      next_addr_q  <= next_addr_d;
      high_six_q   <= high_six_d;
      sum_q        <= sum_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  // held word payload, qualified by pend_valid_q
  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      pend_addr_q <= pend_addr_d;
      pend_word_q <= pend_word_d;
      pend_bsum_q <= pend_bsum_d;
    end
  end

  assign phase_o = phase_q;

endmodule

@@ sv/bin_tl_outreg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bin_tl_outreg
// Result register; frees itself in the cycle its content is taken.
// ----------------------------------------------------------------------------
module bin_tl_outreg import bin_tl_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t res_i,
  input  logic    take_i,
  output logic    space_o,
  output logic    valid_o,
  output result_t res_o
);

  logic    valid_q;
  result_t res_q;

  assign space_o = !valid_q || take_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (take_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

@@ sv/bin_tape_loader.sv @@
`timescale 1ns / 1ps
// Output: a result appears on the master side in the cycle after the byte that causes it.
// Throughput: one tape byte per cycle, set by the single decode stage feeding the
//   result register; s_axis_tready_o drops only while a result is held and not taken.
// Reset: rst_ni low clears the loader to leader search with field, address and sum
//   at zero and no word held, and empties the result register.
// ----------------------------------------------------------------------------
// bin_tape_loader
// BIN format paper-tape loader: decodes leader, field, origin and data frames
// into memory writes, and reports the trailer checksum or a framing error.
// ----------------------------------------------------------------------------
module bin_tape_loader import bin_tl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // tape byte stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] tape_byte
  // result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // [14:0] word_address, [26:15] word_data,
                                        // [27] checksum_good, [39:28] computed_sum
  output logic [1:0]  m_axis_tuser_o,   // [0] write_valid, [1] bad_frame
  output logic        m_axis_tlast_o    // tape_done
);

  logic    in_fire;
  logic    out_space;
  logic    core_res_valid;
  result_t core_res;
  result_t out_res;
  logic [1:0] phase;

  // A byte is taken whenever the result register is free or drains this cycle.
  assign s_axis_tready_o = out_space;
  assign in_fire         = s_axis_tvalid_i && out_space;

  // Decoder plus loader state; updates on every input transfer.
  bin_tl_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (in_fire),
    .byte_i      (s_axis_tdata_i),
    .res_valid_o (core_res_valid),
    .res_o       (core_res),
    .phase_o     (phase)
  );

  // One result slot between decoder and master port.
  bin_tl_outreg u_outreg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (in_fire && core_res_valid),
    .res_i   (core_res),
    .take_i  (m_axis_tready_i),
    .space_o (out_space),
    .valid_o (m_axis_tvalid_o),
    .res_o   (out_res)
  );

  // Pack result fields onto the stream ports.
  assign m_axis_tdata_o = {out_res.computed_sum, out_res.checksum_good,
                           out_res.word_data, out_res.word_address};
  assign m_axis_tuser_o = {out_res.bad_frame, out_res.write_valid};
  assign m_axis_tlast_o = out_res.tape_done;

`ifndef NO_ASSERTIONS
  // each result is exactly one of write, done or error
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> $onehot({out_res.write_valid, out_res.tape_done,
                                 out_res.bad_frame}))
    else $error("result kind not one-hot");

  // done or error always sends the loader back to leader search
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && core_res_valid && (core_res.tape_done || core_res.bad_frame)
      |=> phase == PH_LEADER)
    else $error("loader did not return to leader search");

  // input is only held off by an undelivered result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o)
    else $error("input stalled with empty result register");

  // checksum status only accompanies the trailer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && out_res.checksum_good |-> out_res.tape_done)
    else $error("checksum_good outside done result");
`endif

endmodule
